[src/pmec_pkg.sv]
package pmec_pkg;

   // orientation count limits and input field count
   localparam int MinOrient    = 2;
   localparam int MaxOrient    = 8;
   localparam int NumOrientDef = 6;
   localparam int NumInFields  = 6;
   localparam int NumPair      = MaxOrient / 2;

   // datapath widths
   localparam int PcW     = 16;           // congruency, Q0.16
   localparam int SqW     = 2 * PcW;      // pc squared
   localparam int TabW    = 17;           // trig table entry, Q.16
   localparam int ProdW   = 48;           // lane product, Q.48
   localparam int SumW    = 51;           // lane sum over all orientations
   localparam int RndW    = SumW + 2;     // scaled sum plus rounding term
   localparam int DenShift = 24;          // Q.48 down to Q.24
   localparam int QW      = RndW - DenShift;
   localparam int DivShift = 32;          // reciprocal scale
   localparam int RecipW  = 32;
   localparam int MulW    = QW + RecipW;
   localparam int MomW    = 26;           // a, b, |c| in Q.24
   localparam int SumAbW  = MomW + 1;
   localparam int RadW    = 2 * MomW;     // c^2 + (a-b)^2
   localparam int RootW   = MomW;
   localparam int OutW    = 17;           // Q1.16
   localparam int OutShift = 9;           // halve and go from Q.24 to Q.16
   localparam int FinW    = SumAbW + 1;

   localparam logic [TabW-1:0] OneQ16 = TabW'(65536);
   localparam logic [OutW-1:0] OutMax = '1;
   localparam logic [FinW-1:0] OutRound = FinW'(1) << (OutShift - 1);

   // cos^2 of theta_k = k*pi/n, Q.16, row n
   localparam logic [TabW-1:0] Cos2Tab [0:MaxOrient][0:MaxOrient-1] = '{
      '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
      '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
      '{17'd65536, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
      '{17'd65536, 17'd16384, 17'd16384, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
      '{17'd65536, 17'd32768, 17'd0, 17'd32768, 17'd0, 17'd0, 17'd0, 17'd0},
      '{17'd65536, 17'd42894, 17'd6258, 17'd6258, 17'd42894, 17'd0, 17'd0, 17'd0},
      '{17'd65536, 17'd49152, 17'd16384, 17'd0, 17'd16384, 17'd49152, 17'd0, 17'd0},
      '{17'd65536, 17'd53199, 17'd25476, 17'd3245, 17'd3245, 17'd25476, 17'd53199,
        17'd0},
      '{17'd65536, 17'd55938, 17'd32768, 17'd9598, 17'd0, 17'd9598, 17'd32768,
        17'd55938}
   };

   // cos*sin of theta_k, signed Q.16, row n
   localparam logic signed [TabW-1:0] CsTab [0:MaxOrient][0:MaxOrient-1] = '{
      '{17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd0, 17'sd28378, -17'sd28378, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd0, 17'sd32768, 17'sd0, -17'sd32768, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
      '{17'sd0, 17'sd31164, 17'sd19261, -17'sd19261, -17'sd31164, 17'sd0, 17'sd0,
        17'sd0},
      '{17'sd0, 17'sd28378, 17'sd28378, 17'sd0, -17'sd28378, -17'sd28378, 17'sd0,
        17'sd0},
      '{17'sd0, 17'sd25619, 17'sd31946, 17'sd14218, -17'sd14218, -17'sd31946,
        -17'sd25619, 17'sd0},
      '{17'sd0, 17'sd23170, 17'sd32768, 17'sd23170, 17'sd0, -17'sd23170,
        -17'sd32768, -17'sd23170}
   };

   typedef struct packed {
      logic        [ProdW-1:0] xx;
      logic        [ProdW-1:0] yy;
      logic signed [ProdW-1:0] xy;
   } lane_prod_type;

   typedef struct packed {
      logic [SumAbW-1:0] sum_ab;
      logic [RadW-1:0]   radicand;
   } sqrt_in_type;

   typedef struct packed {
      logic [OutW-1:0] edge_strength;
      logic [OutW-1:0] corner_strength;
   } result_type;

endpackage

[src/pmec_if.sv]
interface pmec_req_if;
   logic                       valid;
   logic                       ready;
   logic [pmec_pkg::PcW-1:0]   pc_orient_0;
   logic [pmec_pkg::PcW-1:0]   pc_orient_1;
   logic [pmec_pkg::PcW-1:0]   pc_orient_2;
   logic [pmec_pkg::PcW-1:0]   pc_orient_3;
   logic [pmec_pkg::PcW-1:0]   pc_orient_4;
   logic [pmec_pkg::PcW-1:0]   pc_orient_5;

   modport source (
      output valid, pc_orient_0, pc_orient_1, pc_orient_2, pc_orient_3, pc_orient_4,
             pc_orient_5,
      input  ready
   );
   modport sink (
      input  valid, pc_orient_0, pc_orient_1, pc_orient_2, pc_orient_3, pc_orient_4,
             pc_orient_5,
      output ready
   );
endinterface

interface pmec_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pmec_pkg::OutW-1:0]  edge_strength;
   logic [pmec_pkg::OutW-1:0]  corner_strength;

   modport source (
      output valid, edge_strength, corner_strength,
      input  ready
   );
   modport sink (
      input  valid, edge_strength, corner_strength,
      output ready
   );
endinterface

[src/pmec_project.sv]
module pmec_project #(
   parameter int NumOrient = pmec_pkg::NumOrientDef
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             en,
   input  logic                                             in_valid,
   input  logic [pmec_pkg::MaxOrient-1:0][pmec_pkg::PcW-1:0] pc,
   output logic                                             out_valid,
   output pmec_pkg::lane_prod_type [pmec_pkg::MaxOrient-1:0] prod
);
   import pmec_pkg::*;

   logic [MaxOrient-1:0][SqW-1:0] sq_in, sq_ff;
   logic                          sq_v_ff;
   lane_prod_type [MaxOrient-1:0] prod_in, prod_ff;
   logic                          prod_v_ff;

   // stage 1: square, lanes past the orientation count read as zero
   always_comb begin
      for (int k = 0; k < MaxOrient; k++) begin
         if (k < NumOrient) begin
            sq_in[k] = SqW'(pc[k]) * SqW'(pc[k]);
         end else begin
            sq_in[k] = '0;
         end
      end
   end

   // stage 2: project onto the angle tables
   always_comb begin
      logic        [TabW-1:0] c2;
      logic        [TabW-1:0] s2;
      logic signed [TabW-1:0] cs;
      for (int k = 0; k < MaxOrient; k++) begin
         c2 = Cos2Tab[NumOrient][k];
         s2 = OneQ16 - c2;
         cs = CsTab[NumOrient][k];
         prod_in[k].xx = ProdW'(sq_ff[k]) * ProdW'(c2);
         prod_in[k].yy = ProdW'(sq_ff[k]) * ProdW'(s2);
         prod_in[k].xy = $signed({{(ProdW-SqW){1'b0}}, sq_ff[k]}) * ProdW'(cs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else if (en) begin
         sq_v_ff   <= in_valid;
         prod_v_ff <= sq_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         prod_ff <= prod_in;
      end
   end

   assign out_valid = prod_v_ff;
   assign prod      = prod_ff;

endmodule

[src/pmec_moment.sv]
module pmec_moment #(
   parameter int NumOrient = pmec_pkg::NumOrientDef
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             en,
   input  logic                                             in_valid,
   input  pmec_pkg::lane_prod_type [pmec_pkg::MaxOrient-1:0] prod,
   output logic                                             out_valid,
   output pmec_pkg::sqrt_in_type                            out
);
   import pmec_pkg::*;

   localparam int NumStage = 8;
   localparam int NumCh    = 3;   // xx, yy, |xy|
   localparam logic [RndW-1:0]   RoundAdd = RndW'(NumOrient) << (DenShift - 1);
   localparam logic [RecipW-1:0] Recip    = RecipW'((64'd1 << DivShift) / NumOrient);
   localparam logic [QW-1:0]     NumQ     = QW'(NumOrient);

   logic [NumStage-1:0] v_ff;

   // pair sums
   logic        [SumW-1:0] pxx_in [NumPair];
   logic        [SumW-1:0] pyy_in [NumPair];
   logic signed [SumW-1:0] pxy_in [NumPair];
   logic        [SumW-1:0] pxx_ff [NumPair];
   logic        [SumW-1:0] pyy_ff [NumPair];
   logic signed [SumW-1:0] pxy_ff [NumPair];
   // totals
   logic        [SumW-1:0] txx_in, tyy_in, txx_ff, tyy_ff;
   logic signed [SumW-1:0] txy_in, txy_ff;
   // rounded, shifted dividends
   logic [QW-1:0] y_in [NumCh];
   logic [QW-1:0] y_ff [NumCh];
   // quotient estimate
   logic [QW-1:0] qe_in [NumCh];
   logic [QW-1:0] qe_ff [NumCh];
   logic [QW-1:0] y2_ff [NumCh];
   // moments a, b, |c|
   logic [MomW-1:0] mom_in [NumCh];
   logic [MomW-1:0] mom_ff [NumCh];
   // sum and difference
   logic [SumAbW-1:0] sab_in, sab_ff, sab2_ff;
   logic [MomW-1:0]   dif_in, dif_ff, cm_ff;
   // squares
   logic [RadW-1:0]   csq_in, dsq_in, csq_ff, dsq_ff;
   sqrt_in_type       out_in, out_ff;

   always_comb begin
      for (int j = 0; j < NumPair; j++) begin
         pxx_in[j] = SumW'(prod[2*j].xx) + SumW'(prod[2*j+1].xx);
         pyy_in[j] = SumW'(prod[2*j].yy) + SumW'(prod[2*j+1].yy);
         pxy_in[j] = SumW'($signed(prod[2*j].xy)) + SumW'($signed(prod[2*j+1].xy));
      end
   end

   always_comb begin
      txx_in = '0;
      tyy_in = '0;
      txy_in = '0;
      for (int j = 0; j < NumPair; j++) begin
         txx_in = txx_in + pxx_ff[j];
         tyy_in = tyy_in + pyy_ff[j];
         txy_in = txy_in + pxy_ff[j];
      end
   end

   // round to nearest, ties away from zero: (2s, or 4|s| for xy, + n*2^23) >> 24, then / n
   always_comb begin
      logic [SumW-1:0] mag;
      logic [RndW-1:0] rxx, ryy, rxy;
      mag = txy_ff[SumW-1] ? SumW'(-txy_ff) : SumW'(txy_ff);
      rxx = (RndW'(txx_ff) << 1) + RoundAdd;
      ryy = (RndW'(tyy_ff) << 1) + RoundAdd;
      rxy = (RndW'(mag) << 2) + RoundAdd;
      y_in[0] = rxx[RndW-1:DenShift];
      y_in[1] = ryy[RndW-1:DenShift];
      y_in[2] = rxy[RndW-1:DenShift];
   end

   // reciprocal multiply, may come out one low
   always_comb begin
      logic [MulW-1:0] p;
      for (int i = 0; i < NumCh; i++) begin
         p        = MulW'(y_ff[i]) * MulW'(Recip);
         qe_in[i] = p[MulW-1:DivShift];
      end
   end

   // one-step correction
   always_comb begin
      logic [QW-1:0] r;
      logic [QW-1:0] q;
      for (int i = 0; i < NumCh; i++) begin
         r = y2_ff[i] - QW'(qe_ff[i] * NumQ);
         q = (r >= NumQ) ? qe_ff[i] + QW'(1) : qe_ff[i];
         mom_in[i] = MomW'(q);
      end
   end

   always_comb begin
      sab_in = SumAbW'(mom_ff[0]) + SumAbW'(mom_ff[1]);
      dif_in = (mom_ff[0] >= mom_ff[1]) ? mom_ff[0] - mom_ff[1] : mom_ff[1] - mom_ff[0];
   end

   assign csq_in = RadW'(cm_ff) * RadW'(cm_ff);
   assign dsq_in = RadW'(dif_ff) * RadW'(dif_ff);

   always_comb begin
      out_in.sum_ab   = sab2_ff;
      out_in.radicand = csq_ff + dsq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NumStage-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NumPair; j++) begin
            pxx_ff[j] <= pxx_in[j];
            pyy_ff[j] <= pyy_in[j];
            pxy_ff[j] <= pxy_in[j];
         end
         txx_ff <= txx_in;
         tyy_ff <= tyy_in;
         txy_ff <= txy_in;
         for (int i = 0; i < NumCh; i++) begin
            y_ff[i]   <= y_in[i];
            qe_ff[i]  <= qe_in[i];
            y2_ff[i]  <= y_ff[i];
            mom_ff[i] <= mom_in[i];
         end
         sab_ff  <= sab_in;
         dif_ff  <= dif_in;
         cm_ff   <= mom_ff[2];
         sab2_ff <= sab_ff;
         csq_ff  <= csq_in;
         dsq_ff  <= dsq_in;
         out_ff  <= out_in;
      end
   end

   assign out_valid = v_ff[NumStage-1];
   assign out       = out_ff;

endmodule

[src/pmec_sqrt.sv]
module pmec_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  pmec_pkg::sqrt_in_type            sin,
   output logic                             out_valid,
   output logic [pmec_pkg::RootW-1:0]       root,
   output logic [pmec_pkg::SumAbW-1:0]      sum_ab
);
   import pmec_pkg::*;

   // one root bit per stage, restoring form: rem = v - root^2
   logic [RadW-1:0]   src_rem  [RootW];
   logic [RootW-1:0]  src_root [RootW];
   logic [RadW-1:0]   rem_in   [RootW];
   logic [RadW-1:0]   rem_ff   [RootW];
   logic [RootW-1:0]  root_in  [RootW];
   logic [RootW-1:0]  root_ff  [RootW];
   logic [SumAbW-1:0] tag_in   [RootW];
   logic [SumAbW-1:0] tag_ff   [RootW];
   logic [RootW-1:0]  v_ff;

   always_comb begin
      logic [RadW-1:0] trial;
      src_rem[0]  = sin.radicand;
      src_root[0] = '0;
      tag_in[0]   = sin.sum_ab;
      for (int j = 1; j < RootW; j++) begin
         src_rem[j]  = rem_ff[j-1];
         src_root[j] = root_ff[j-1];
         tag_in[j]   = tag_ff[j-1];
      end
      for (int j = 0; j < RootW; j++) begin
         trial = (RadW'(src_root[j]) << (RootW - j)) |
                 (RadW'(1) << (2 * (RootW - 1 - j)));
         if (src_rem[j] >= trial) begin
            rem_in[j]  = src_rem[j] - trial;
            root_in[j] = src_root[j] | (RootW'(1) << (RootW - 1 - j));
         end else begin
            rem_in[j]  = src_rem[j];
            root_in[j] = src_root[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[RootW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < RootW; j++) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            tag_ff[j]  <= tag_in[j];
         end
      end
   end

   assign out_valid = v_ff[RootW-1];
   assign root      = root_ff[RootW-1];
   assign sum_ab    = tag_ff[RootW-1];

endmodule

[src/phase_moment_edge_corner.sv]
// channel   dir  interface          payload
// req_bus   in   pmec_req_if.sink   pc_orient_0..5, 16b unsigned Q0.16 each
// rsp_bus   out  pmec_rsp_if.source edge_strength, corner_strength, 17b Q1.16
//
// one beat in per cycle, one beat out per cycle, while rsp is not stalled;
// 37 register stages lie between the accepting edge and the beat on rsp
// (2 projection stages, 8 moment/divide stages, 26 square-root stages, output reg)
// the 26-stage square root, one root bit per stage, sets the latency
// reset is synchronous and clears only the valid bits; data registers are not reset
// a stalled rsp lets one more beat fall into a skid register; req ready then drops
// and the whole pipe holds until the skid register drains
module phase_moment_edge_corner #(
   parameter int NUM_ORIENT = pmec_pkg::NumOrientDef
) (
   input  logic       clock,
   input  logic       reset,
   pmec_req_if.sink   req_bus,
   pmec_rsp_if.source rsp_bus
);
   import pmec_pkg::*;

   // orientation count clamped into the supported range
   localparam int NumOrientEff = (NUM_ORIENT < MinOrient) ? MinOrient :
                                 (NUM_ORIENT > MaxOrient) ? MaxOrient : NUM_ORIENT;

   // global pipe advance: held only while the skid register is full
   logic en;

   logic [MaxOrient-1:0][PcW-1:0] pc_lanes;
   logic                          proj_valid;
   lane_prod_type [MaxOrient-1:0] proj_prod;
   logic                          mom_valid;
   sqrt_in_type                   mom_out;
   logic                          sq_valid;
   logic [RootW-1:0]              sq_root;
   logic [SumAbW-1:0]             sq_sum_ab;

   result_type fin;          // eigenvalues of the beat leaving the pipe
   result_type out_in, out_ff;
   result_type skid_in, skid_ff;
   logic       out_v_in, out_v_ff;
   logic       skid_v_in, skid_v_ff;

   // orientations with no input field carry zero
   always_comb begin
      pc_lanes    = '0;
      pc_lanes[0] = req_bus.pc_orient_0;
      pc_lanes[1] = req_bus.pc_orient_1;
      pc_lanes[2] = req_bus.pc_orient_2;
      pc_lanes[3] = req_bus.pc_orient_3;
      pc_lanes[4] = req_bus.pc_orient_4;
      pc_lanes[5] = req_bus.pc_orient_5;
   end

   assign en            = !skid_v_ff;
   assign req_bus.ready = en;

   // pc^2 times cos^2, sin^2 and cos*sin per lane
   pmec_project #(
      .NumOrient (NumOrientEff)
   ) u_project (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .pc        (pc_lanes),
      .out_valid (proj_valid),
      .prod      (proj_prod)
   );

   // lane sums, scaling by 2/n and 4/n, then a+b and c^2+(a-b)^2
   pmec_moment #(
      .NumOrient (NumOrientEff)
   ) u_moment (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (proj_valid),
      .prod      (proj_prod),
      .out_valid (mom_valid),
      .out       (mom_out)
   );

   // floor square root of the discriminant; a+b rides along
   pmec_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mom_valid),
      .sin       (mom_out),
      .out_valid (sq_valid),
      .root      (sq_root),
      .sum_ab    (sq_sum_ab)
   );

   // (a+b +/- d)/2 to Q.16 with ties up, saturate; corner clamps at zero
   always_comb begin
      logic [FinW-1:0] hi;
      logic [FinW-1:0] lo;
      logic [FinW-1:0] hi_q;
      logic [FinW-1:0] lo_q;
      hi   = FinW'(sq_sum_ab) + FinW'(sq_root) + OutRound;
      lo   = FinW'(sq_sum_ab) - FinW'(sq_root) + OutRound;
      hi_q = hi >> OutShift;
      lo_q = lo >> OutShift;
      fin.edge_strength = (hi_q > FinW'(OutMax)) ? OutMax : OutW'(hi_q);
      if (FinW'(sq_sum_ab) <= FinW'(sq_root)) begin
         fin.corner_strength = '0;
      end else begin
         fin.corner_strength = (lo_q > FinW'(OutMax)) ? OutMax : OutW'(lo_q);
      end
   end

   // output register plus skid register
   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         // pipe is held; drain skid into the output when the sink takes a beat
         if (rsp_bus.ready) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (!out_v_ff || rsp_bus.ready) begin
         out_v_in = sq_valid;
         out_in   = fin;
      end else if (sq_valid) begin
         // output stalled, catch the beat leaving the pipe this cycle
         skid_v_in = 1'b1;
         skid_in   = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid           = out_v_ff;
   assign rsp_bus.edge_strength   = out_ff.edge_strength;
   assign rsp_bus.corner_strength = out_ff.corner_strength;

endmodule

[src/pmec_checker.sv]
module pmec_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [pmec_pkg::OutW-1:0] rsp_edge_strength,
   input logic [pmec_pkg::OutW-1:0] rsp_corner_strength
);
   import pmec_pkg::*;

   // a stalled beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a stalled beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_edge_strength) && $stable(rsp_corner_strength))
      else $error("rsp payload changed while stalled");

   // smaller eigenvalue never exceeds the larger one
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_corner_strength <= rsp_edge_strength)
      else $error("corner strength above edge strength");

   // input back-pressure only follows a stalled output beat
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("req ready low without a stalled rsp beat");

   // whenever the output holds no beat, input is open
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req ready low with an empty output");

endmodule

bind phase_moment_edge_corner pmec_checker u_pmec_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_edge_strength   (rsp_bus.edge_strength),
   .rsp_corner_strength (rsp_bus.corner_strength)
);
